### rtl/core/bbh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbh_pkg: shared types and constants of the orbit histogram
// Fixed-point formats, register indexes and the controller state type.
// ----------------------------------------------------------------------------
package bbh_pkg;

	localparam int MAX_COLS_DEF   = 1024;
	localparam int MAX_ROWS_DEF   = 1024;
	localparam int COUNT_BITS_DEF = 16;

	// coordinates: signed, 28 fraction bits; scales: 16 fraction bits
	localparam int FRAC_BITS  = 28;
	localparam int SCALE_FRAC = 16;
	localparam int BIN_SHIFT  = FRAC_BITS + SCALE_FRAC;

	localparam int Z_W    = 31;          // live iterate, |z part| <= 2
	localparam int PROD_W = 2 * Z_W;     // exact square / cross product
	localparam int MAG_W  = 60;          // re^2 + im^2
	localparam int BPRD_W = 60;          // (z - min) * scale

	localparam int CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ITER_LIMIT  = 3'd0,
		CFG_WORLD_MIN_X = 3'd1,
		CFG_WORLD_MIN_Y = 3'd2,
		CFG_SCALE_X     = 3'd3,
		CFG_SCALE_Y     = 3'd4,
		CFG_IMG_W       = 3'd5,
		CFG_IMG_H       = 3'd6,
		CFG_SPARE       = 3'd7
	} cfg_idx_t;

	localparam logic [15:0] ITER_LIMIT_RST  = 16'd1000;
	localparam logic [31:0] WORLD_MIN_X_RST = -32'sd564415879;
	localparam logic [31:0] WORLD_MIN_Y_RST = -32'sd332245248;
	localparam logic [25:0] SCALE_X_RST     = 26'd20296302;
	localparam logic [25:0] SCALE_Y_RST     = 26'd20289683;
	localparam logic [10:0] IMG_W_RST       = 11'd1024;
	localparam logic [10:0] IMG_H_RST       = 11'd768;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_DRAIN,
		ST_RD_ADDR,
		ST_RD_DATA
	} state_t;

endpackage

`default_nettype wire

### rtl/core/buddhabrot_orbit_histogram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// buddhabrot_orbit_histogram: orbit tracer with a histogram store
// Traces z = z*z + c, replays escaping orbits into a bin memory, reads bins.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the bin memory, one bin a
// cycle; busy stays high until it ends, configuration writes are taken
// meanwhile. An item is taken when start is high and busy low. A trace item
// iterates with a multiply step and an add/test step per iterate, through
// the one squaring unit: an escape at step E is found in the add/test step
// of iterate E-1 when a part leaves radius 2, in that of iterate E when only
// |z|^2 passes 4, and a point that never escapes ends with the add/test step
// of iterate L at iteration limit L; an escaping point then replays its orbit
// through the same unit and the bin memory's read-modify-write port. A read
// item runs an address step and a data step. In every case the result shows
// in the cycle after the last step, for exactly one cycle with done high, and
// must be taken then: the receiver cannot stall. busy is low in the cycle done
// shows, so the next item may be taken at once.
// ----------------------------------------------------------------------------
module buddhabrot_orbit_histogram #(
	parameter int MAX_COLS   = bbh_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS   = bbh_pkg::MAX_ROWS_DEF,
	parameter int COUNT_BITS = bbh_pkg::COUNT_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	// command side
	input  wire                          start,
	output logic                         busy,
	input  wire                          kind,
	input  wire  signed [31:0]           c_re,
	input  wire  signed [31:0]           c_im,
	input  wire         [9:0]            read_col,
	input  wire         [9:0]            read_row,
	// result side
	output logic                         done,
	output logic                         escaped,
	output logic        [15:0]           escape_step,
	output logic        [15:0]           bin_value,
	// configuration
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire  [bbh_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire         [31:0]           cfg_data
);

	localparam int DEPTH  = MAX_COLS * MAX_ROWS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int WIDE_W = 26;    // holds row*MAX_COLS+col at the largest size
	localparam logic [12:0] COLS_LIM = 13'(MAX_COLS);
	localparam logic [12:0] ROWS_LIM = 13'(MAX_ROWS);

	localparam logic signed [33:0] TWO_FX = 34'sd2 <<< bbh_pkg::FRAC_BITS;
	localparam logic [bbh_pkg::MAG_W-1:0] FOUR_FX2 =
		bbh_pkg::MAG_W'(1) << (2 * bbh_pkg::FRAC_BITS + 2);
	localparam logic signed [bbh_pkg::BPRD_W-1:0] NEG_ONE_BIN =
		-(bbh_pkg::BPRD_W'(1) << bbh_pkg::BIN_SHIFT);

	// configuration registers
	logic        [15:0] iter_limit_q;
	logic signed [31:0] world_min_x_q, world_min_y_q;
	logic        [25:0] scale_x_q, scale_y_q;
	logic        [10:0] img_w_q, img_h_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_limit_q  <= bbh_pkg::ITER_LIMIT_RST;
			world_min_x_q <= bbh_pkg::WORLD_MIN_X_RST;
			world_min_y_q <= bbh_pkg::WORLD_MIN_Y_RST;
			scale_x_q     <= bbh_pkg::SCALE_X_RST;
			scale_y_q     <= bbh_pkg::SCALE_Y_RST;
			img_w_q       <= bbh_pkg::IMG_W_RST;
			img_h_q       <= bbh_pkg::IMG_H_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (bbh_pkg::cfg_idx_t'(cfg_index))
				bbh_pkg::CFG_ITER_LIMIT:  iter_limit_q  <= cfg_data[15:0];
				bbh_pkg::CFG_WORLD_MIN_X: world_min_x_q <= cfg_data;
				bbh_pkg::CFG_WORLD_MIN_Y: world_min_y_q <= cfg_data;
				bbh_pkg::CFG_SCALE_X:     scale_x_q     <= cfg_data[25:0];
				bbh_pkg::CFG_SCALE_Y:     scale_y_q     <= cfg_data[25:0];
				bbh_pkg::CFG_IMG_W:       img_w_q       <= cfg_data[10:0];
				bbh_pkg::CFG_IMG_H:       img_h_q       <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// bins in use, limited to the store
	logic [12:0] w_eff, h_eff;
	assign w_eff = ({2'b00, img_w_q} > COLS_LIM) ? COLS_LIM : {2'b00, img_w_q};
	assign h_eff = ({2'b00, img_h_q} > ROWS_LIM) ? ROWS_LIM : {2'b00, img_h_q};

	// controller
	bbh_pkg::state_t state_q, state_d;

	logic               pass2_q;          // replay pass
	logic        [15:0] n_q;              // number of the iterate in re_q/im_q
	logic        [15:0] esc_q;
	logic signed [31:0] cre_q, cim_q;
	logic        [9:0]  rcol_q, rrow_q;
	logic        [ADDR_W-1:0] clr_q;

	logic signed [bbh_pkg::Z_W-1:0]    re_q, im_q;
	logic signed [bbh_pkg::PROD_W-1:0] rr_q, ii_q, ri_q;

	// add/test cycle: |z|^2 of iterate n_q, range test of iterate n_q+1
	logic [bbh_pkg::MAG_W-1:0]  mag;
	logic                       mag_esc;
	logic signed [bbh_pkg::PROD_W-1:0] nr_full, ni_full;
	logic                       rng_esc;
	logic                       at_depth, at_last;

	assign mag = bbh_pkg::MAG_W'(rr_q) + bbh_pkg::MAG_W'(ii_q);
	assign mag_esc = mag > FOUR_FX2;
	assign nr_full = ((rr_q - ii_q) >>> bbh_pkg::FRAC_BITS) + bbh_pkg::PROD_W'(cre_q);
	assign ni_full = (ri_q >>> (bbh_pkg::FRAC_BITS - 1)) + bbh_pkg::PROD_W'(cim_q);
	assign rng_esc = (nr_full > bbh_pkg::PROD_W'(TWO_FX)) || (nr_full < -bbh_pkg::PROD_W'(TWO_FX))
		|| (ni_full > bbh_pkg::PROD_W'(TWO_FX)) || (ni_full < -bbh_pkg::PROD_W'(TWO_FX));
	assign at_depth = (n_q == iter_limit_q);
	assign at_last  = ((n_q + 16'd1) == esc_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bbh_pkg::ST_CLEAR:
				if (clr_q == ADDR_W'(DEPTH - 1)) state_d = bbh_pkg::ST_IDLE;
			bbh_pkg::ST_IDLE:
				if (start) state_d = kind ? bbh_pkg::ST_RD_ADDR : bbh_pkg::ST_MUL;
			bbh_pkg::ST_MUL:
				state_d = bbh_pkg::ST_ADD;
			bbh_pkg::ST_ADD: begin
				if (pass2_q) begin
					state_d = at_last ? bbh_pkg::ST_DRAIN : bbh_pkg::ST_MUL;
				end else if (mag_esc || (rng_esc && !at_depth)) begin
					state_d = bbh_pkg::ST_MUL;     // on to the replay
				end else if (at_depth) begin
					state_d = bbh_pkg::ST_IDLE;
				end else begin
					state_d = bbh_pkg::ST_MUL;
				end
			end
			bbh_pkg::ST_DRAIN:   state_d = bbh_pkg::ST_IDLE;
			bbh_pkg::ST_RD_ADDR: state_d = bbh_pkg::ST_RD_DATA;
			bbh_pkg::ST_RD_DATA: state_d = bbh_pkg::ST_IDLE;
			default:             state_d = bbh_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= bbh_pkg::ST_CLEAR;
		else         state_q <= state_d;
	end

	// result strobe and fields, decided combinationally, shown from registers
	logic        res_fire, res_esc;
	logic [15:0] res_step, res_bin;
	logic [COUNT_BITS-1:0] rd_q;
	logic        rd_ok;
	logic [31:0] rd_ext;

	assign rd_ok  = ({3'b000, rcol_q} < COLS_LIM) && ({3'b000, rrow_q} < ROWS_LIM);
	assign rd_ext = 32'(rd_q);

	always_comb begin
		res_fire = 1'b0;
		res_esc  = 1'b0;
		res_step = '0;
		res_bin  = '0;
		unique case (state_q)
			// at the limit only the iterate's own |z|^2 still counts
			bbh_pkg::ST_ADD:
				if (!pass2_q && !mag_esc && at_depth) res_fire = 1'b1;
			bbh_pkg::ST_DRAIN: begin
				res_fire = 1'b1;
				res_esc  = 1'b1;
				res_step = esc_q;
			end
			bbh_pkg::ST_RD_DATA: begin
				res_fire = 1'b1;
				res_bin  = rd_ok ? rd_ext[15:0] : 16'd0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= res_fire;
	end

	always_ff @(posedge clk) begin
		if (res_fire) begin
			escaped     <= res_esc;
			escape_step <= res_step;
			bin_value   <= res_bin;
		end
	end

	assign busy = (state_q != bbh_pkg::ST_IDLE);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass2_q <= 1'b0;
			n_q     <= '0;
			esc_q   <= '0;
			clr_q   <= '0;
		end else begin
			if (state_q == bbh_pkg::ST_CLEAR) clr_q <= clr_q + ADDR_W'(1);
			if (state_q == bbh_pkg::ST_IDLE && start) begin
				pass2_q <= 1'b0;
				n_q     <= '0;
			end else if (state_q == bbh_pkg::ST_ADD) begin
				if (!pass2_q && mag_esc) begin
					pass2_q <= 1'b1;
					esc_q   <= n_q;
					n_q     <= '0;
				end else if (!pass2_q && rng_esc && !at_depth) begin
					pass2_q <= 1'b1;
					esc_q   <= n_q + 16'd1;
					n_q     <= '0;
				end else begin
					n_q <= n_q + 16'd1;
				end
			end
		end
	end

	// payload: captured item, iterate and products
	always_ff @(posedge clk) begin
		if (state_q == bbh_pkg::ST_IDLE && start) begin
			cre_q  <= c_re;
			cim_q  <= c_im;
			rcol_q <= read_col;
			rrow_q <= read_row;
			re_q   <= '0;
			im_q   <= '0;
		end else if (state_q == bbh_pkg::ST_MUL) begin
			rr_q <= re_q * re_q;
			ii_q <= im_q * im_q;
			ri_q <= re_q * im_q;
		end else if (state_q == bbh_pkg::ST_ADD) begin
			if (!pass2_q && (mag_esc || (rng_esc && !at_depth))) begin
				re_q <= '0;                // replay from zero
				im_q <= '0;
			end else begin
				re_q <= nr_full[bbh_pkg::Z_W-1:0];
				im_q <= ni_full[bbh_pkg::Z_W-1:0];
			end
		end
	end

	// bin pipeline: s1 products, s2 address and memory read, then write back
	logic bin_go;
	assign bin_go = (state_q == bbh_pkg::ST_MUL) && pass2_q && (n_q != 16'd0);

	logic signed [32:0] dx, dy;
	logic signed [26:0] sx, sy;
	assign dx = 33'(re_q) - 33'(world_min_x_q);
	assign dy = 33'(im_q) - 33'(world_min_y_q);
	assign sx = $signed({1'b0, scale_x_q});
	assign sy = $signed({1'b0, scale_y_q});

	logic                              valid_s1;
	logic signed [bbh_pkg::BPRD_W-1:0] px_s1, py_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else         valid_s1 <= bin_go;
	end

	// operands sign-extended to the product width first
	always_ff @(posedge clk) begin
		if (bin_go) begin
			px_s1 <= bbh_pkg::BPRD_W'(dx) * bbh_pkg::BPRD_W'(sx);
			py_s1 <= bbh_pkg::BPRD_W'(dy) * bbh_pkg::BPRD_W'(sy);
		end
	end

	// truncation toward zero: an offset in (-1, 0) bins to 0
	logic [15:0] col_b, row_b;
	logic        x_ok, y_ok, bin_ok;
	logic [WIDE_W-1:0] bin_wide, rd_wide;
	logic [ADDR_W-1:0] bin_addr;

	assign col_b = px_s1[bbh_pkg::BPRD_W-1] ? 16'd0 : px_s1[bbh_pkg::BIN_SHIFT +: 16];
	assign row_b = py_s1[bbh_pkg::BPRD_W-1] ? 16'd0 : py_s1[bbh_pkg::BIN_SHIFT +: 16];
	assign x_ok  = (px_s1 > NEG_ONE_BIN) && (col_b < {3'b000, w_eff});
	assign y_ok  = (py_s1 > NEG_ONE_BIN) && (row_b < {3'b000, h_eff});
	assign bin_ok = valid_s1 && x_ok && y_ok;
	assign bin_wide = WIDE_W'(row_b[12:0]) * WIDE_W'(MAX_COLS) + WIDE_W'(col_b[12:0]);
	assign bin_addr = bin_wide[ADDR_W-1:0];
	assign rd_wide  = WIDE_W'(rrow_q) * WIDE_W'(MAX_COLS) + WIDE_W'(rcol_q);

	logic              valid_s2;
	logic [ADDR_W-1:0] addr_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else         valid_s2 <= bin_ok;
	end

	always_ff @(posedge clk) begin
		if (valid_s1) addr_s2 <= bin_addr;
	end

	// bin memory: one write and one read port, registered read data.
	// Bin updates come at most one per iterate, so a read never sees a stale entry.
	logic [COUNT_BITS-1:0] mem [DEPTH];
	logic                  mem_we, mem_re;
	logic [ADDR_W-1:0]     mem_wa, mem_ra;
	logic [COUNT_BITS-1:0] mem_wd;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = addr_s2;
		mem_wd = rd_q + COUNT_BITS'(1);      // wraps at the count width
		if (state_q == bbh_pkg::ST_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
			mem_wd = '0;
		end else if (valid_s2) begin
			mem_we = 1'b1;
		end
		mem_re = valid_s1 || (state_q == bbh_pkg::ST_RD_ADDR);
		mem_ra = valid_s1 ? bin_addr : rd_wide[ADDR_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (mem_re) rd_q <= mem[mem_ra];
	end

endmodule

`default_nettype wire

### rtl/core/bbh_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbh_checker: port-level checks of the orbit histogram
// Watches the command, result and status ports over time.
// ----------------------------------------------------------------------------
module bbh_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        start,
	input wire        busy,
	input wire        done,
	input wire        escaped,
	input wire [15:0] escape_step,
	input wire [15:0] bin_value
);

	// an accepted item keeps the block busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy low after accept");

	// results never come in back-to-back cycles
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("two result beats in a row");

	// a non-escaping or read result has no step
	a_no_step: assert property (@(posedge clk) disable iff (!arst_n)
		done && !escaped |-> escape_step == 16'd0) else $error("step without escape");

	// an escape has a step and no bin count
	a_esc_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done && escaped |-> escape_step != 16'd0 && bin_value == 16'd0)
		else $error("bad escape result");

endmodule

bind buddhabrot_orbit_histogram bbh_checker u_bbh_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.escaped     (escaped),
	.escape_step (escape_step),
	.bin_value   (bin_value)
);

`default_nettype wire

### bench/buddhabrot_orbit_histogram_tb.sv
// ----------------------------------------------------------------------------
// buddhabrot_orbit_histogram_tb: self-checking bench of the orbit histogram
// Drives trace and read commands, keeps its own bit-exact model of the
// iteration, the replay binning and the bin store, and checks every result
// beat against it across several register settings and idle patterns.
// ----------------------------------------------------------------------------
module buddhabrot_orbit_histogram_tb;

	localparam int  NBINS      = 1024 * 1024;
	localparam int  STORE_COLS = 1024;
	localparam int  STORE_ROWS = 1024;
	// clearing pass plus the directed items and 300 random ones, with margin
	localparam longint CYCLE_LIMIT = 12_000_000;

	// fixed-point helpers, 28 fraction bits
	localparam longint ONE      = 64'sd1 << bbh_pkg::FRAC_BITS;
	localparam longint TWO      = 64'sd2 << bbh_pkg::FRAC_BITS;
	localparam longint FOUR_SQ  = 64'sd4 << (2 * bbh_pkg::FRAC_BITS);
	localparam int     KIND_TRACE = 0;
	localparam int     KIND_READ  = 1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic kind = 1'b0;
	logic signed [31:0] c_re = '0;
	logic signed [31:0] c_im = '0;
	logic [9:0] read_col = '0;
	logic [9:0] read_row = '0;
	logic cfg_valid = 1'b0;
	logic [bbh_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic busy, done, escaped, cfg_ready;
	logic [15:0] escape_step, bin_value;

	buddhabrot_orbit_histogram dut (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .kind(kind), .c_re(c_re), .c_im(c_im),
		.read_col(read_col), .read_row(read_row),
		.done(done), .escaped(escaped), .escape_step(escape_step),
		.bin_value(bin_value),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// one expected result beat
	typedef struct {
		logic        escaped;
		logic [15:0] escape_step;
		logic [15:0] bin_value;
	} orbit_result_t;

	orbit_result_t pending_results[$];

	// shadow of the register file
	logic [15:0] depth_q;
	longint      min_x_q, min_y_q, scale_x_q, scale_y_q;
	logic [10:0] width_q, height_q;

	// shadow of the bin store plus a list of bins known to be nonzero
	logic [15:0] bin_counts [0:NBINS-1];
	int          touched_bins[$];

	int     sender_idle_pct = 0;
	int     mismatches = 0;
	longint cycles = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// ---------------------------------------------------------------- model
	// one step of z = z*z + c; floor shifts on the exact products.
	// Returns 1 when the new iterate lies outside radius 2.
	function automatic bit orbit_advance(inout longint re, inout longint im,
			input longint cre, input longint cim);
		longint nr, ni;
		nr = ((re * re - im * im) >>> bbh_pkg::FRAC_BITS) + cre;
		ni = ((re * im) >>> (bbh_pkg::FRAC_BITS - 1)) + cim;
		re = nr;
		im = ni;
		// a part beyond 2 escapes before the square could grow too large
		if (nr > TWO || nr < -TWO || ni > TWO || ni < -TWO)
			return 1'b1;
		return (nr * nr + ni * ni) > FOUR_SQ;
	endfunction

	// world offset times scale, truncated toward zero
	function automatic longint bin_coord(input longint offs, input longint scale);
		longint p;
		p = offs * scale;
		if (p >= 0)
			return p >>> bbh_pkg::BIN_SHIFT;
		return -((-p) >>> bbh_pkg::BIN_SHIFT);
	endfunction

	function automatic void count_iterate(input longint re, input longint im);
		longint u, v, w, h;
		int     idx;
		w = (width_q > STORE_COLS) ? STORE_COLS : width_q;
		h = (height_q > STORE_ROWS) ? STORE_ROWS : height_q;
		u = bin_coord(re - min_x_q, scale_x_q);
		v = bin_coord(im - min_y_q, scale_y_q);
		if (u < 0 || v < 0 || u >= w || v >= h)
			return;
		idx = int'(v) * STORE_COLS + int'(u);
		if (bin_counts[idx] == 16'd0 && touched_bins.size() < 4000)
			touched_bins.push_back(idx);
		bin_counts[idx] = bin_counts[idx] + 16'd1;
	endfunction

	// expected beat for one accepted command; updates the store on traces
	function automatic orbit_result_t predict_command(input logic k,
			input logic signed [31:0] cr, input logic signed [31:0] ci,
			input logic [9:0] col, input logic [9:0] row);
		orbit_result_t r;
		longint re, im, cre, cim;
		int     esc;
		r.escaped = 1'b0;
		r.escape_step = '0;
		r.bin_value = '0;
		if (k == 1'b1) begin
			r.bin_value = bin_counts[int'(row) * STORE_COLS + int'(col)];
			return r;
		end
		cre = cr;
		cim = ci;
		re = 0;
		im = 0;
		esc = 0;
		for (int n = 0; n < int'(depth_q); n++) begin
			if (orbit_advance(re, im, cre, cim)) begin
				esc = n + 1;
				break;
			end
		end
		if (esc != 0) begin
			// replay: each iterate after z0 and before the escaping one that falls in view is counted
			re = 0;
			im = 0;
			for (int n = 1; n < esc; n++) begin
				void'(orbit_advance(re, im, cre, cim));
				count_iterate(re, im);
			end
			r.escaped = 1'b1;
			r.escape_step = esc[15:0];
		end
		return r;
	endfunction

	// ---------------------------------------------------------------- checker
	// done is sampled at the rising edge; the beat cannot be held off
	always @(posedge clk) begin
		orbit_result_t exp_r;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: esc=%0d step=%0d bin=%0d",
						escaped, escape_step, bin_value);
			end else begin
				exp_r = pending_results.pop_front();
				if (escaped !== exp_r.escaped || escape_step !== exp_r.escape_step ||
						bin_value !== exp_r.bin_value) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp esc=%0d step=%0d bin=%0d, got esc=%0d step=%0d bin=%0d",
							exp_r.escaped, exp_r.escape_step, exp_r.bin_value,
							escaped, escape_step, bin_value);
				end
			end
		end
	end

	// ---------------------------------------------------------------- drivers
	// register write; called at a falling edge, returns at a falling edge
	task automatic write_reg(input bbh_pkg::cfg_idx_t idx, input logic [31:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			bbh_pkg::CFG_ITER_LIMIT:  depth_q = data[15:0];
			bbh_pkg::CFG_WORLD_MIN_X: min_x_q = longint'($signed(data));
			bbh_pkg::CFG_WORLD_MIN_Y: min_y_q = longint'($signed(data));
			bbh_pkg::CFG_SCALE_X:     scale_x_q = data[25:0];
			bbh_pkg::CFG_SCALE_Y:     scale_y_q = data[25:0];
			bbh_pkg::CFG_IMG_W:       width_q = data[10:0];
			bbh_pkg::CFG_IMG_H:       height_q = data[10:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// one command beat; start stays high into the next command unless a gap
	// is drawn, so start only ever changes once per falling edge
	task automatic send_command(input logic k, input logic signed [31:0] cr,
			input logic signed [31:0] ci, input logic [9:0] col, input logic [9:0] row);
		start = 1'b1;
		kind = k;
		c_re = cr;
		c_im = ci;
		read_col = col;
		read_row = row;
		do @(posedge clk); while (busy);
		pending_results.push_back(predict_command(k, cr, ci, col, row));
		@(negedge clk);
		if ($urandom_range(99) < sender_idle_pct) begin
			start = 1'b0;
			repeat ($urandom_range(6, 1)) @(negedge clk);
		end
	endtask

	task automatic trace(input longint cr, input longint ci);
		send_command(KIND_TRACE, cr[31:0], ci[31:0], '0, '0);
	endtask

	task automatic read_bin(input int col, input int row);
		send_command(KIND_READ, $urandom(), $urandom(), col[9:0], row[9:0]);
	endtask

	// all results in before registers move; every command yields one beat
	task automatic drain();
		start = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_view(input int depth, input longint mx, input longint my,
			input int sx, input int sy, input int w, input int h);
		drain();
		write_reg(bbh_pkg::CFG_ITER_LIMIT, depth);
		write_reg(bbh_pkg::CFG_WORLD_MIN_X, mx[31:0]);
		write_reg(bbh_pkg::CFG_WORLD_MIN_Y, my[31:0]);
		write_reg(bbh_pkg::CFG_SCALE_X, sx);
		write_reg(bbh_pkg::CFG_SCALE_Y, sy);
		write_reg(bbh_pkg::CFG_IMG_W, w);
		write_reg(bbh_pkg::CFG_IMG_H, h);
	endtask

	// ---------------------------------------------------------------- tests
	// extremes of c, bounded and unbounded orbits, edge bins
	task automatic test_directed();
		trace(-64'sd2147483648, -64'sd2147483648);   // far outside: step 1
		trace(64'sd2147483647, 64'sd2147483647);
		trace(0, 0);                                 // never escapes
		trace(-ONE, 0);                              // orbit alternates between 0 and -1
		trace(ONE / 4 + ONE / 100, 0);               // slow escape near cusp
		trace(-ONE - ONE / 2 + ONE / 50, ONE / 100); // long orbit in view
		trace(-2 * ONE, 0);                          // on the boundary, bounded
		read_bin(0, 0);
		read_bin(1023, 1023);
		read_bin(1023, 0);
		for (int i = 0; i < touched_bins.size() && i < 4; i++)
			read_bin(touched_bins[i] % STORE_COLS, touched_bins[i] / STORE_COLS);
		// offset just below the left edge truncates to column 0 and counts
		set_view(100, 1, -ONE * 2, 1 << 24, 1 << 20, 1024, 1024);
		trace(0, ONE + ONE / 2);
		trace(0, ONE + ONE / 2);
		read_bin(0, 896);
		read_bin(0, 895);
		// zero depth: nothing escapes
		set_view(0, -ONE * 2, -ONE * 2, 1 << 22, 1 << 22, 1024, 1024);
		trace(ONE / 2, ONE / 2);
		trace(-64'sd2147483648, 0);
		// oversized image, largest scale and depth
		set_view(65535, -ONE * 2, -ONE * 2, 26'h3FFFFFF, 26'h3FFFFFF, 2047, 2047);
		trace(ONE / 3, ONE / 2);
		trace(-ONE * 3 / 4, ONE / 8);
		// zero scale puts every iterate in bin 0; zero size bins nothing
		set_view(200, -ONE * 2, -ONE * 2, 0, 0, 0, 1024);
		trace(ONE / 3, ONE / 2);
		read_bin(0, 0);
		set_view(200, -ONE * 2, -ONE * 2, 0, 0, 1, 1);
		trace(ONE / 3, ONE / 2);
		read_bin(0, 0);
	endtask

	// random mix: mostly points near the set, some wild ones, reads of hit and random bins
	task automatic test_random_view(input int n_items, input int idle_pct);
		int     depth, sel, idx;
		longint cr, ci;
		sender_idle_pct = idle_pct;
		depth = ($urandom_range(9) == 0) ? $urandom_range(1000, 400) : $urandom_range(250, 20);
		set_view(depth,
			-ONE * 2 - longint'($urandom_range(ONE / 4)),
			-ONE * 3 / 2 - longint'($urandom_range(ONE / 4)),
			$urandom_range(1 << 25, 1 << 22), $urandom_range(1 << 25, 1 << 22),
			$urandom_range(1024, 1), $urandom_range(1024, 1));
		for (int i = 0; i < n_items; i++) begin
			sel = $urandom_range(99);
			if (sel < 65) begin
				cr = longint'($urandom_range(295279001 + 563714457)) - 563714457;
				ci = longint'($urandom_range(2 * 348966092)) - 348966092;
				trace(cr, ci);
			end else if (sel < 77) begin
				trace(longint'($signed($urandom())), longint'($signed($urandom())));
			end else if (sel < 92 && touched_bins.size() != 0) begin
				idx = touched_bins[$urandom_range(touched_bins.size() - 1)];
				read_bin(idx % STORE_COLS, idx / STORE_COLS);
			end else begin
				read_bin($urandom_range(1023), $urandom_range(1023));
			end
		end
	endtask

	initial begin
		depth_q = bbh_pkg::ITER_LIMIT_RST;
		min_x_q = longint'($signed(bbh_pkg::WORLD_MIN_X_RST));
		min_y_q = longint'($signed(bbh_pkg::WORLD_MIN_Y_RST));
		scale_x_q = bbh_pkg::SCALE_X_RST;
		scale_y_q = bbh_pkg::SCALE_Y_RST;
		width_q = bbh_pkg::IMG_W_RST;
		height_q = bbh_pkg::IMG_H_RST;
		for (int i = 0; i < NBINS; i++)
			bin_counts[i] = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset view first, then the rest
		test_directed();
		for (int p = 0; p < 4; p++) test_random_view(25, 19);
		for (int p = 0; p < 4; p++) test_random_view(25, 49);
		for (int p = 0; p < 4; p++) test_random_view(25, 0);

		drain();
		repeat (50) @(negedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
